FILE: hdl/utf8_codepoint_counter_assert.svh
// Assertion macros for the code point counter.
`ifndef UTF8_CODEPOINT_COUNTER_ASSERT_SVH
`define UTF8_CODEPOINT_COUNTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UCC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define UCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UCC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define UCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/utf8cc_pkg.sv
package utf8cc_pkg;

   localparam int OUT_BITS = 32;
   localparam int INC_BITS = 3;
   localparam int VAL_BITS = 21;

   localparam logic [7:0] TOP_MASK   = 8'h80;
   localparam logic [7:0] CONT_MASK  = 8'hc0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'he0;
   localparam logic [7:0] LEAD2_CODE = 8'hc0;
   localparam logic [7:0] LEAD3_MASK = 8'hf0;
   localparam logic [7:0] LEAD3_CODE = 8'he0;
   localparam logic [7:0] LEAD4_MASK = 8'hf8;
   localparam logic [7:0] LEAD4_CODE = 8'hf0;
   localparam logic [7:0] PAYLOAD6   = 8'h3f;
   localparam logic [7:0] PAYLOAD5   = 8'h1f;
   localparam logic [7:0] PAYLOAD4   = 8'h0f;
   localparam logic [7:0] PAYLOAD3   = 8'h07;

   localparam logic [VAL_BITS-1:0] MIN_W2    = 21'h000080;
   localparam logic [VAL_BITS-1:0] MIN_W3    = 21'h000800;
   localparam logic [VAL_BITS-1:0] MIN_W4    = 21'h010000;
   localparam logic [VAL_BITS-1:0] MAX_CP    = 21'h10ffff;
   localparam logic [VAL_BITS-1:0] SURR_LO   = 21'h00d800;
   localparam logic [VAL_BITS-1:0] SURR_HI   = 21'h00dfff;

   localparam logic [2:0] WIDTH_NONE = 3'd0;
   localparam logic [2:0] WIDTH_TWO  = 3'd2;
   localparam logic [2:0] WIDTH_THREE = 3'd3;
   localparam logic [2:0] WIDTH_FOUR = 3'd4;

   typedef struct packed {
      logic [2:0]          expected_width;
      logic [1:0]          bytes_taken;
      logic [VAL_BITS-1:0] partial_value;
   } seq_state_type;

endpackage

FILE: hdl/utf8cc_decode.sv
module utf8cc_decode (
   input  utf8cc_pkg::seq_state_type        seq_cur,
   input  logic [7:0]                       data_byte,
   input  logic                             last_byte,
   output utf8cc_pkg::seq_state_type        seq_next,
   output logic [utf8cc_pkg::INC_BITS-1:0]  inc
);
   import utf8cc_pkg::*;

   function automatic logic seq_valid(input logic [2:0] w, input logic [VAL_BITS-1:0] v);
      logic ok;
      ok = 1'b1;
      if (w == WIDTH_TWO && v < MIN_W2) ok = 1'b0;
      if (w == WIDTH_THREE && v < MIN_W3) ok = 1'b0;
      if (w == WIDTH_FOUR && v < MIN_W4) ok = 1'b0;
      if (v > MAX_CP) ok = 1'b0;
      if (v >= SURR_LO && v <= SURR_HI) ok = 1'b0;
      return ok;
   endfunction

   logic                is_cont;
   logic                st_open;
   logic [2:0]          st_width;
   logic [VAL_BITS-1:0] st_value;
   logic [VAL_BITS-1:0] pv;
   logic [1:0]          tk;
   logic [2:0]          tk_ext;
   logic [2:0]          open_inc;

   // Decode of the byte as the start of a new sequence.
   always_comb begin
      st_open  = 1'b0;
      st_width = WIDTH_NONE;
      st_value = '0;
      if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         st_width = WIDTH_TWO;
         st_value = {13'd0, data_byte & PAYLOAD5};
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         st_width = WIDTH_THREE;
         st_value = {13'd0, data_byte & PAYLOAD4};
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         st_width = WIDTH_FOUR;
         st_value = {13'd0, data_byte & PAYLOAD3};
      end
      // A lead byte that is also the final byte stays a single count.
      if ((data_byte & TOP_MASK) != 8'h00 && st_width != WIDTH_NONE && !last_byte) begin
         st_open = 1'b1;
      end
   end

   always_comb begin
      is_cont  = (data_byte & CONT_MASK) == CONT_CODE;
      pv       = {seq_cur.partial_value[VAL_BITS-7:0], data_byte[5:0]};
      tk       = seq_cur.bytes_taken + 2'd1;
      tk_ext   = {1'b0, tk};
      open_inc = 3'd1 + {1'b0, seq_cur.bytes_taken};
      seq_next = '0;
      inc      = '0;
      if (seq_cur.expected_width != WIDTH_NONE && is_cont) begin
         if (tk_ext + 3'd1 >= seq_cur.expected_width) begin
            inc = seq_valid(seq_cur.expected_width, pv) ? 3'd1 : seq_cur.expected_width;
         end else if (last_byte) begin
            inc = tk_ext + 3'd1;
         end else begin
            seq_next.expected_width = seq_cur.expected_width;
            seq_next.bytes_taken    = tk;
            seq_next.partial_value  = pv;
         end
      end else begin
         // A broken sequence counts its lead and taken bytes, then the byte
         // is decoded again as a fresh start.
         if (seq_cur.expected_width != WIDTH_NONE) begin
            inc = open_inc;
         end
         if (st_open) begin
            seq_next.expected_width = st_width;
            seq_next.partial_value  = st_value;
         end else begin
            inc = inc + 3'd1;
         end
      end
   end

endmodule

FILE: hdl/utf8cc_counter.sv
module utf8cc_counter #(
   parameter int COUNT_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             flush,
   input  logic [utf8cc_pkg::INC_BITS-1:0]  inc,
   output logic [utf8cc_pkg::OUT_BITS-1:0]  total
);
   import utf8cc_pkg::*;

   logic [COUNT_BITS-1:0] running_count_ff;
   logic [COUNT_BITS-1:0] running_count_in;
   logic [COUNT_BITS:0]   sum_wide;
   logic [COUNT_BITS-1:0] sat;

   always_comb begin
      sum_wide = {1'b0, running_count_ff} + {{(COUNT_BITS + 1 - INC_BITS){1'b0}}, inc};
      sat      = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
      running_count_in = running_count_ff;
      if (step) begin
         running_count_in = flush ? '0 : sat;
      end
   end

   generate
      if (COUNT_BITS > OUT_BITS) begin : g_clamp
         assign total = (|sat[COUNT_BITS-1:OUT_BITS]) ? '1 : sat[OUT_BITS-1:0];
      end else if (COUNT_BITS == OUT_BITS) begin : g_same
         assign total = sat;
      end else begin : g_extend
         assign total = {{(OUT_BITS - COUNT_BITS){1'b0}}, sat};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         running_count_ff <= '0;
      end else begin
         running_count_ff <= running_count_in;
      end
   end

endmodule

FILE: hdl/utf8_codepoint_counter.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_stall | req_data_byte[7:0], req_last_byte
// rsp     | out       | rsp_valid / rsp_stall | rsp_codepoint_count[31:0]
//
// One byte is taken per cycle while no final byte is held by a stalled result;
// each byte passes through the input register, and the count of a finished
// string is loaded into the result register as its final byte leaves the input register.
// The sequence state and running count update in one pass, which sets the rate.
// Synchronous reset clears the sequence state, the count and both valid flags.
// A stalled result holds only a final byte in the input register; other bytes
// keep flowing.
module utf8_codepoint_counter #(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_codepoint_count
);
   import utf8cc_pkg::*;

   `include "utf8_codepoint_counter_assert.svh"

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                s1_last_ff;
   logic                s1_adv;
   logic                s1_fire;
   logic                req_take;
   logic                out_load;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [OUT_BITS-1:0] rsp_count_ff;
   logic [OUT_BITS-1:0] total;
   logic [INC_BITS-1:0] inc;
   seq_state_type       seq_ff;
   seq_state_type       seq_in;
   seq_state_type       seq_next;

   // Only a final byte needs room in the result register.
   assign s1_adv    = !s1_last_ff || !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign out_load  = s1_fire && s1_last_ff;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   assign seq_in       = s1_fire ? seq_next : seq_ff;

   utf8cc_decode u_decode (
      .seq_cur   (seq_ff),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .seq_next  (seq_next),
      .inc       (inc)
   );

   utf8cc_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .flush (s1_last_ff),
      .inc   (inc),
      .total (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (out_load) begin
         rsp_count_ff <= total;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_codepoint_count = rsp_count_ff;

   `UCC_ASSERT_NEXT(a_final_gives_result, clock, reset, out_load, rsp_valid, "final byte gave no result")
   `UCC_ASSERT_NEXT(a_final_closes_seq, clock, reset, out_load, seq_ff.expected_width == WIDTH_NONE, "sequence left open after final byte")
   `UCC_ASSERT_SAME(a_closed_no_taken, clock, reset, seq_ff.expected_width == WIDTH_NONE, seq_ff.bytes_taken == 2'd0, "bytes taken with no open sequence")

endmodule

FILE: tb/sv/utf8_codepoint_counter_tb.sv
module utf8_codepoint_counter_tb;
   import utf8cc_pkg::*;

   localparam int COUNT_BITS = 32;
   localparam longint unsigned TALLY_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam longint unsigned OUT_MAX = 64'hffff_ffff;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 8;

   typedef logic [7:0] byte_seq_type[$];

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_codepoint_count;

   // Decoder state mirrored for prediction.
   logic [2:0]          open_width = WIDTH_NONE;
   logic [1:0]          conts_seen = '0;
   logic [VAL_BITS-1:0] cp_bits = '0;
   longint unsigned     cp_tally = 0;

   logic [31:0] expected_counts[$];
   logic [31:0] want_count;
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          gaps_enabled = 1'b0;
   bit          hold_pending = 1'b0;

   utf8_codepoint_counter #(
      .COUNT_BITS(COUNT_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_codepoint_count(rsp_codepoint_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void bump_tally(input int unsigned n);
      if (cp_tally > TALLY_MAX) cp_tally = TALLY_MAX;
      if (TALLY_MAX - cp_tally < n) cp_tally = TALLY_MAX;
      else cp_tally += n;
   endfunction

   function automatic void clear_sequence();
      open_width = WIDTH_NONE;
      conts_seen = '0;
      cp_bits = '0;
   endfunction

   function automatic void begin_sequence(input logic [7:0] b, input logic fin);
      logic [2:0]          w;
      logic [VAL_BITS-1:0] v;
      w = WIDTH_NONE;
      v = '0;
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         w = WIDTH_TWO;
         v = VAL_BITS'(b & PAYLOAD5);
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         w = WIDTH_THREE;
         v = VAL_BITS'(b & PAYLOAD4);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         w = WIDTH_FOUR;
         v = VAL_BITS'(b & PAYLOAD3);
      end
      // ASCII, stray bytes and a lead that ends the string all count once.
      if (w == WIDTH_NONE || fin) begin
         bump_tally(1);
      end else begin
         open_width = w;
         conts_seen = '0;
         cp_bits = v;
      end
   endfunction

   function automatic bit is_scalar(input logic [2:0] w, input logic [VAL_BITS-1:0] v);
      if (w == WIDTH_TWO && v < MIN_W2) return 1'b0;
      if (w == WIDTH_THREE && v < MIN_W3) return 1'b0;
      if (w == WIDTH_FOUR && v < MIN_W4) return 1'b0;
      if (v > MAX_CP) return 1'b0;
      if (v >= SURR_LO && v <= SURR_HI) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic fin);
      if (open_width == WIDTH_NONE) begin
         begin_sequence(b, fin);
      end else if ((b & CONT_MASK) == CONT_CODE) begin
         cp_bits = {cp_bits[VAL_BITS-7:0], b[5:0]};
         conts_seen = conts_seen + 2'd1;
         if (int'(conts_seen) + 1 >= int'(open_width)) begin
            bump_tally(is_scalar(open_width, cp_bits) ? 1 : int'(open_width));
            clear_sequence();
         end else if (fin) begin
            bump_tally(1 + int'(conts_seen));
            clear_sequence();
         end
      end else begin
         // The sequence is broken: lead and taken bytes count singly, and the
         // offending byte is decoded again as a fresh start.
         bump_tally(1 + int'(conts_seen));
         clear_sequence();
         begin_sequence(b, fin);
      end
      if (fin) begin
         expected_counts.push_back(cp_tally > OUT_MAX ? 32'hffff_ffff : cp_tally[31:0]);
         clear_sequence();
         cp_tally = 0;
      end
   endfunction

   function automatic void append_encoded(ref byte_seq_type s, input logic [20:0] v,
                                          input int w);
      case (w)
         1: s.push_back(8'(v[6:0]));
         2: s.push_back(LEAD2_CODE | 8'(v[10:6]));
         3: s.push_back(LEAD3_CODE | 8'(v[15:12]));
         default: s.push_back(LEAD4_CODE | 8'(v[20:18]));
      endcase
      for (int k = w - 2; k >= 0; k--) begin
         s.push_back(CONT_CODE | (8'(v >> (6 * k)) & PAYLOAD6));
      end
   endfunction

   function automatic void append_random_char(ref byte_seq_type s);
      int                  pick;
      int                  w;
      int                  drop;
      logic [20:0]         v;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         w = $urandom_range(1, 4);
         case (w)
            1: v = 21'($urandom_range(0, MIN_W2 - 1));
            2: v = 21'($urandom_range(MIN_W2, MIN_W3 - 1));
            3: begin
               v = 21'($urandom_range(MIN_W3, MIN_W4 - 1));
               // Move out of the surrogate block, staying in the 3-byte range.
               if (v >= SURR_LO && v <= SURR_HI) v = v ^ 21'h002000;
            end
            default: v = 21'($urandom_range(MIN_W4, MAX_CP));
         endcase
         append_encoded(s, v, w);
      end else if (pick < 75) begin
         case ($urandom_range(0, 2))
            0: begin
               w = $urandom_range(2, 4);
               if (w == 2) v = 21'($urandom_range(0, MIN_W2 - 1));
               else if (w == 3) v = 21'($urandom_range(0, MIN_W3 - 1));
               else v = 21'($urandom_range(0, MIN_W4 - 1));
            end
            1: begin
               w = 3;
               v = 21'($urandom_range(SURR_LO, SURR_HI));
            end
            default: begin
               w = 4;
               v = 21'($urandom_range(MAX_CP + 1, 21'h1fffff));
            end
         endcase
         append_encoded(s, v, w);
      end else if (pick < 85) begin
         w = $urandom_range(2, 4);
         v = 21'($urandom);
         append_encoded(s, v, w);
         drop = $urandom_range(1, w - 1);
         repeat (drop) void'(s.pop_back());
      end else if (pick < 92) begin
         s.push_back(CONT_CODE | (8'($urandom) & PAYLOAD6));
      end else begin
         s.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   // Called and returns at a falling edge; valid stays up for back-to-back bytes.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (gaps_enabled && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      do @(posedge clock); while (req_stall);
      predict_byte(b, fin);
      @(negedge clock);
   endtask

   task automatic send_string(input byte_seq_type s);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_counts.size() != 0 || hold_pending);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed_strings();
      byte_seq_type s;
      gaps_enabled = 1'b0;
      s = {8'h00};
      send_string(s);
      // Largest one-, three- and four-byte forms and the smallest two-byte form,
      // then a stray continuation and an invalid lead byte.
      s = {8'h7f, 8'hc2, 8'h80, 8'hef, 8'hbf, 8'hbf, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
           8'h80, 8'hff};
      send_string(s);
      // Overlong, surrogate, above the last code point, a bad continuation,
      // and a sequence cut short by the end of the string.
      s = {8'hc0, 8'h80, 8'hed, 8'ha0, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80,
           8'he2, 8'h41, 8'he2, 8'h82};
      send_string(s);
      s = {8'hc2};
      send_string(s);
      wait_for_drain();
   endtask

   task automatic test_random_strings(input int byte_budget, input bit with_gaps);
      byte_seq_type s;
      int           sent;
      int           nchars;
      gaps_enabled = with_gaps;
      sent = 0;
      while (sent < byte_budget) begin
         s.delete();
         nchars = $urandom_range(1, 8);
         repeat (nchars) append_random_char(s);
         send_string(s);
         sent += s.size();
      end
      wait_for_drain();
   endtask

   // The receiver holds off while many short strings arrive, so final bytes
   // pile up and the block has to stall its input.
   task automatic test_result_backpressure();
      byte_seq_type s;
      gaps_enabled = 1'b0;
      hold_pending = 1'b1;
      repeat (50) begin
         s.delete();
         repeat ($urandom_range(1, 2)) append_random_char(s);
         send_string(s);
      end
      wait_for_drain();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_pending = 1'b0;
         end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("codepoint_count: no result expected, actual %0d", rsp_codepoint_count);
            mismatches++;
         end else begin
            want_count = expected_counts.pop_front();
            if (rsp_codepoint_count !== want_count) begin
               $error("codepoint_count: expected %0d, actual %0d", want_count,
                      rsp_codepoint_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_random_strings(700, 1'b1);
      test_result_backpressure();
      test_random_strings(250, 1'b0);

      if (mismatches == 0 && expected_counts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
